FILE: rtl/core/dda_pkg.sv
`timescale 1ns / 1ps

package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int COLOR_BITS     = 24;

    localparam logic [COLOR_BITS-1:0] COLOR_RESET = 24'h00FF00;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic div_step;
        logic emit;
        logic cfg_we;
    } t_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic active;
        logic out_full;
    } t_status;

endpackage

FILE: rtl/core/dda_line_rasterizer.sv
`timescale 1ns / 1ps
// Line rasterizer with fixed-point position stepping.
// Input channel (i_valid / o_stall): i_func = load takes two endpoints and
// prepares a line; i_func = step asks for the next pixel. Output channel
// (o_valid / i_stall) carries one pixel word: coordinates, color and a flag
// on the final pixel. A line of length L (longer axis span) yields L+1 words.
// Loads give no word, and steps with no line in progress are dropped.
// After a load the block stalls its input while two restoring dividers,
// one per axis with a shared divisor, each produce a quotient bit per cycle.
// Steps are then taken one per cycle while the receiver does not stall; each
// pixel appears in the output register the cycle after its step is accepted.
// When the receiver stalls with a word pending, the input is stalled too and
// the pending word holds until taken.
// The color register is written through i_cfg_valid / i_cfg_data; the port
// is always ready. Write it only while the block is idle.
// Reset (synchronous, active low) ends any line, empties the output register
// and sets the color to green.

module dda_line_rasterizer import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_func,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pix_x,
    output logic [COORD_BITS-1:0] o_pix_y,
    output logic [COLOR_BITS-1:0] o_pix_color,
    output logic                  o_last_pixel,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [COLOR_BITS-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dda_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_func      (i_func),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_stall     (o_stall),
        .o_cmd       (cmd)
    );

    dda_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_stall      (i_stall),
        .i_x_start    (i_x_start),
        .i_y_start    (i_y_start),
        .i_x_end      (i_x_end),
        .i_y_end      (i_y_end),
        .i_cfg_data   (i_cfg_data),
        .o_status     (status),
        .o_valid      (o_valid),
        .o_pix_x      (o_pix_x),
        .o_pix_y      (o_pix_y),
        .o_pix_color  (o_pix_color),
        .o_last_pixel (o_last_pixel)
    );

endmodule

FILE: rtl/core/dda_ctrl.sv
`timescale 1ns / 1ps

module dda_ctrl import dda_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_func,
    input  logic    i_stall,
    input  logic    i_cfg_valid,
    input  t_status i_status,
    output logic    o_stall,
    output t_cmd    o_cmd
);

    localparam int CW = $clog2(FRAC_BITS + 1);

    typedef enum logic {
        S_IDLE,
        S_DIV
    } t_state;

    t_state         r_state;
    logic [CW-1:0]  r_cnt;
    logic           ready;
    logic           accept;

    // take a word only while idle and the output slot is free or draining
    assign ready  = (r_state == S_IDLE) && (!i_status.out_full || !i_stall);
    assign accept = i_valid && ready;
    assign o_stall = !ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = accept && (i_func == FUNC_LOAD);
        o_cmd.emit     = accept && (i_func == FUNC_STEP) && i_status.active;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.cfg_we   = i_cfg_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.load) begin
                        r_state <= S_DIV;
                        r_cnt   <= CW'(FRAC_BITS);
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/dda_datapath.sv
`timescale 1ns / 1ps

module dda_datapath import dda_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_stall,
    input  logic [COORD_BITS-1:0] i_x_start,
    input  logic [COORD_BITS-1:0] i_y_start,
    input  logic [COORD_BITS-1:0] i_x_end,
    input  logic [COORD_BITS-1:0] i_y_end,
    input  logic [COLOR_BITS-1:0] i_cfg_data,
    output t_status               o_status,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_pix_x,
    output logic [COORD_BITS-1:0] o_pix_y,
    output logic [COLOR_BITS-1:0] o_pix_color,
    output logic                  o_last_pixel
);

    localparam int C = COORD_BITS;
    localparam int F = FRAC_BITS;
    localparam int P = C + F + 2;

    localparam logic signed [P-1:0] HALF = P'(1) <<< (F - 1);

    logic [COLOR_BITS-1:0]  r_color;
    logic signed [P-1:0]    r_pos_x, r_pos_y;
    logic [F:0]             r_q_x, r_q_y;
    logic [C-1:0]           r_rem_x, r_rem_y;
    logic                   r_bit_x, r_bit_y;
    logic                   r_neg_x, r_neg_y;
    logic [C-1:0]           r_len;
    logic [C:0]             r_left;
    logic                   r_out_valid;

    logic signed [C:0]      dx, dy;
    logic [C-1:0]           mag_x, mag_y, len;
    logic [C:0]             trial_x, trial_y;
    logic                   ge_x, ge_y;

    always_comb begin
        dx    = signed'({1'b0, i_x_end}) - signed'({1'b0, i_x_start});
        dy    = signed'({1'b0, i_y_end}) - signed'({1'b0, i_y_start});
        mag_x = dx[C] ? C'(-dx) : dx[C-1:0];
        mag_y = dy[C] ? C'(-dy) : dy[C-1:0];
        len   = (mag_x >= mag_y) ? mag_x : mag_y;

        // restoring division, one quotient bit per cycle
        trial_x = {r_rem_x, r_bit_x};
        trial_y = {r_rem_y, r_bit_y};
        ge_x    = (r_len != '0) && (trial_x >= {1'b0, r_len});
        ge_y    = (r_len != '0) && (trial_y >= {1'b0, r_len});
    end

    function automatic logic [C-1:0] pixel_of(input logic signed [P-1:0] pos);
        logic [C-1:0] v;
        if (pos[P-1]) begin
            v = '0;
        end else if (pos[P-2]) begin
            v = '1;
        end else begin
            v = pos[C+F-1:F];
        end
        return v;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color     <= COLOR_RESET;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.cfg_we) begin
                r_color <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_left <= {1'b0, len} + 1'b1;
            end else if (i_cmd.emit) begin
                r_left <= r_left - 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_len   <= len;
            r_neg_x <= dx[C];
            r_neg_y <= dy[C];
            r_rem_x <= mag_x >> 1;
            r_rem_y <= mag_y >> 1;
            r_bit_x <= mag_x[0];
            r_bit_y <= mag_y[0];
            r_q_x   <= '0;
            r_q_y   <= '0;
            r_pos_x <= dx[C] ? signed'(P'({i_x_start, F'(0)})) - HALF
                             : signed'(P'({i_x_start, F'(0)})) + HALF;
            r_pos_y <= dy[C] ? signed'(P'({i_y_start, F'(0)})) - HALF
                             : signed'(P'({i_y_start, F'(0)})) + HALF;
        end else if (i_cmd.div_step) begin
            r_rem_x <= ge_x ? C'(trial_x - {1'b0, r_len}) : trial_x[C-1:0];
            r_rem_y <= ge_y ? C'(trial_y - {1'b0, r_len}) : trial_y[C-1:0];
            r_bit_x <= 1'b0;
            r_bit_y <= 1'b0;
            r_q_x   <= {r_q_x[F-1:0], ge_x};
            r_q_y   <= {r_q_y[F-1:0], ge_y};
        end else if (i_cmd.emit) begin
            r_pos_x <= r_neg_x ? r_pos_x - signed'(P'(r_q_x)) : r_pos_x + signed'(P'(r_q_x));
            r_pos_y <= r_neg_y ? r_pos_y - signed'(P'(r_q_y)) : r_pos_y + signed'(P'(r_q_y));
        end
    end

    // output register; hold while stalled
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_pix_x      <= pixel_of(r_pos_x);
            o_pix_y      <= pixel_of(r_pos_y);
            o_pix_color  <= r_color;
            o_last_pixel <= (r_left == (C+1)'(1));
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status.active   = (r_left != '0);
    assign o_status.out_full = r_out_valid;

endmodule
